/* design/chs_pkg.sv */
// ----------------------------------------------------------------------------
// Circular heading smoother package
// Shared widths, angle constants, configuration register indexes, item codes
// and the short-way angle difference.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

  localparam int HEAD_W  = 15;
  localparam int RAW_W   = 16;
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int THR_W   = 14;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [RAW_W-1:0]    FULL_TURN   = 16'd23040;
  localparam logic signed [15:0]  FULL_TURN_S = 16'sd23040;
  localparam logic signed [15:0]  HALF_TURN_S = 16'sd11520;

  localparam logic [SPEED_W-1:0] MIN_SPEED_RESET        = 16'd1000;
  localparam logic [GAIN_W-1:0]  SMOOTHING_GAIN_RESET   = 16'd8192;
  localparam logic [THR_W-1:0]   REDRAW_THRESHOLD_RESET = 14'd320;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SPEED        = 2'd0,
    REG_SMOOTHING_GAIN   = 2'd1,
    REG_REDRAW_THRESHOLD = 2'd2
  } reg_index_t;

  typedef logic [HEAD_W-1:0] heading_t;

  // Signed difference a - b taken the short way round, in (-half, half].
  function automatic logic signed [HEAD_W-1:0] short_diff(input heading_t a,
                                                          input heading_t b);
    logic signed [15:0] d;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    if (d > HALF_TURN_S) begin
      d = d - FULL_TURN_S;
    end else if (d <= -HALF_TURN_S) begin
      d = d + FULL_TURN_S;
    end
    return d[HEAD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/circular_heading_smoother_core.sv */
// ----------------------------------------------------------------------------
// Circular heading smoother core
// Exponential moving average of a course over ground, taken on the circle,
// with sample gating on fix, range and speed, and a redraw flag when the
// smoothed heading leaves the last drawn heading by the threshold.
// ----------------------------------------------------------------------------
//   channel  | handshake             | word
//   ---------+-----------------------+----------------------------------------
//   in       | in_valid / in_ready   | kind, has_fix, speed, raw_heading
//   out      | out_valid / out_ready | redraw, heading_valid, smoothed_heading
//   cfg      | cfg_write             | cfg_index, cfg_data
//
// One word is taken every cycle unless the output stalls; its result is
// registered. The rate is set by the heading feedback loop: difference, gain
// multiply, wrap and redraw compare all complete in the cycle a word leaves
// the input register. Reset restores the register defaults and clears the
// heading. When out_ready is low the input register holds one further word.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_heading_smoother_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         kind,
  input  wire                         has_fix,
  input  wire [chs_pkg::SPEED_W-1:0]  speed,
  input  wire [chs_pkg::RAW_W-1:0]    raw_heading,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        redraw,
  output logic                        heading_valid,
  output logic [chs_pkg::HEAD_W-1:0]  smoothed_heading,
  input  wire                         cfg_write,
  input  wire [chs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [chs_pkg::CFG_W-1:0]    cfg_data
);
  import chs_pkg::*;

  logic [SPEED_W-1:0] min_speed;
  logic [GAIN_W-1:0]  smoothing_gain;
  logic [THR_W-1:0]   redraw_threshold;

  logic               s1_valid;
  logic               s1_kind;
  logic               s1_has_fix;
  logic [SPEED_W-1:0] s1_speed;
  logic [RAW_W-1:0]   s1_raw_heading;
  logic               s1_advance;

  logic     have_heading;
  logic     have_drawn;
  heading_t current_heading;
  heading_t drawn_heading;

  logic     have_heading_next;
  logic     have_drawn_next;
  heading_t current_heading_next;
  heading_t drawn_heading_next;
  logic     redraw_next;

  logic                     sample_ok;
  heading_t                 sample_heading;
  logic signed [HEAD_W-1:0] sample_diff;
  logic signed [31:0]       product;
  logic signed [16:0]       step;
  logic signed [17:0]       sum;
  heading_t                 smoothed;
  heading_t                 new_heading;
  logic signed [HEAD_W-1:0] draw_diff;
  logic signed [HEAD_W-1:0] draw_neg;
  logic [THR_W-1:0]         draw_mag;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed        <= MIN_SPEED_RESET;
      smoothing_gain   <= SMOOTHING_GAIN_RESET;
      redraw_threshold <= REDRAW_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_MIN_SPEED:        min_speed        <= cfg_data;
        REG_SMOOTHING_GAIN:   smoothing_gain   <= cfg_data;
        REG_REDRAW_THRESHOLD: redraw_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_kind        <= kind;
      s1_has_fix     <= has_fix;
      s1_speed       <= speed;
      s1_raw_heading <= raw_heading;
    end
  end

  always_comb begin
    sample_ok = s1_has_fix && (s1_raw_heading <= FULL_TURN) && (s1_speed >= min_speed);
    sample_heading = (s1_raw_heading == FULL_TURN) ? '0 : s1_raw_heading[HEAD_W-1:0];
    sample_diff = short_diff(sample_heading, current_heading);
    product = $signed({1'b0, smoothing_gain}) * sample_diff;
    step = product[31:15];
    sum = $signed({3'b000, current_heading}) + $signed({step[16], step});
    if (sum < 0) begin
      smoothed = HEAD_W'(sum + $signed({2'b00, FULL_TURN}));
    end else if (sum >= $signed({2'b00, FULL_TURN})) begin
      smoothed = HEAD_W'(sum - $signed({2'b00, FULL_TURN}));
    end else begin
      smoothed = sum[HEAD_W-1:0];
    end
    new_heading = have_heading ? smoothed : sample_heading;
    draw_diff = short_diff(new_heading, drawn_heading);
    draw_neg  = -draw_diff;
    draw_mag  = draw_diff[HEAD_W-1] ? draw_neg[THR_W-1:0] : draw_diff[THR_W-1:0];

    have_heading_next    = have_heading;
    have_drawn_next      = have_drawn;
    current_heading_next = current_heading;
    drawn_heading_next   = drawn_heading;
    redraw_next          = 1'b0;
    if (s1_kind == KIND_CLEAR) begin
      have_heading_next    = 1'b0;
      have_drawn_next      = 1'b0;
      current_heading_next = '0;
      drawn_heading_next   = '0;
    end else if (sample_ok) begin
      have_heading_next    = 1'b1;
      current_heading_next = new_heading;
      if (!have_drawn || (draw_mag >= redraw_threshold)) begin
        have_drawn_next    = 1'b1;
        drawn_heading_next = new_heading;
        redraw_next        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_heading    <= 1'b0;
      have_drawn      <= 1'b0;
      current_heading <= '0;
      drawn_heading   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s1_advance) begin
        have_heading    <= have_heading_next;
        have_drawn      <= have_drawn_next;
        current_heading <= current_heading_next;
        drawn_heading   <= drawn_heading_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_advance) begin
      redraw           <= redraw_next;
      heading_valid    <= have_heading_next;
      smoothed_heading <= have_heading_next ? current_heading_next : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_heading_in_range: assert property (@(posedge clk) disable iff (rst)
    current_heading < FULL_TURN[HEAD_W-1:0] && drawn_heading < FULL_TURN[HEAD_W-1:0])
    else $error("stored heading outside one turn");

  a_drawn_tracks_heading: assert property (@(posedge clk) disable iff (rst)
    have_drawn == have_heading)
    else $error("drawn flag out of step with heading flag");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_kind == KIND_CLEAR |=> !have_heading && current_heading == '0)
    else $error("clear word left heading state");

  a_redraw_needs_heading: assert property (@(posedge clk) disable iff (rst)
    out_valid && redraw |-> heading_valid)
    else $error("redraw flagged without a heading");

  a_invalid_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !heading_valid |-> smoothed_heading == '0)
    else $error("heading shown while not valid");
`endif

endmodule

`default_nettype wire
